/* src/motor_speed_pid_controller_defines.svh */
// Assertion macros shared by the motor speed PID controller RTL.
// Each macro expects clk and arst_n in the scope that uses it.
`ifndef MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MSPID_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MSPID_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mspid_pkg.sv */
// Package for the motor speed PID controller: widths, limits, register map,
// controller states and the request struct of the serial multiply unit.
// No dependencies.
package mspid_pkg;

	localparam int SPEED_BITS    = 15;
	localparam int INTEGRAL_BITS = 40;

	localparam int ERR_W    = 17;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int SP_W     = 10;
	localparam int DRIVE_W  = 12;
	localparam int GAIN_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int STIME_W  = 8;
	localparam int GAIN_FRAC = 8;
	localparam int OUT_FRAC  = 16;

	localparam int RAW_W     = ((SPEED_BITS > ERR_W) ? SPEED_BITS : ERR_W) + 2;
	localparam int INC_W     = ERR_W + STIME_W + 1;
	localparam int SAT_W     = ((INTEGRAL_BITS > INC_W) ? INTEGRAL_BITS : INC_W) + 1;
	localparam int ITG_OP_W  = (INTEGRAL_BITS > 47) ? 48 : INTEGRAL_BITS;
	localparam int ITG_CMP_W = (INTEGRAL_BITS > 48) ? INTEGRAL_BITS : 48;
	localparam int TOT_W     = 47;
	localparam int PID_W     = TOT_W - GAIN_FRAC;
	localparam int ACC_W     = ((ITG_OP_W > PID_W) ? ITG_OP_W : PID_W) + GAIN_W + 3;
	localparam int CNT_W     = $clog2(GAIN_W);

	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	localparam int      ERR_MAX    = 65535;
	localparam int      ERR_MIN    = -65536;
	localparam longint  ITG_LIM    = 64'sd70368744177664;
	localparam longint  SUM_LIM    = 64'sd35184372088832;
	localparam int      TRUNC_BIAS = 255;
	localparam int      DRIVE_MAX  = 4095;

	localparam logic [DRIVE_W-1:0]  NOMINAL_DRIVE_RST = 12'd737;
	localparam logic [SP_W-1:0]     TARGET_LEVEL_RST  = 10'd20;
	localparam logic [PERIOD_W-1:0] HALF_PERIOD_RST   = 16'd1000;
	localparam logic [STIME_W-1:0]  SAMPLE_TIME_RST   = 8'd20;
	localparam logic [GAIN_W-1:0]   PGAIN_RST         = 16'd2048;
	localparam logic [GAIN_W-1:0]   IGAIN_RST         = 16'd333;
	localparam logic [GAIN_W-1:0]   DGAIN_RST         = 16'd26;
	localparam logic [GAIN_W-1:0]   OUT_SCALE_RST     = 16'd524;

	typedef enum logic [2:0] {
		REG_NOMINAL_DRIVE,
		REG_TARGET_LEVEL,
		REG_HALF_PERIOD,
		REG_SAMPLE_TIME,
		REG_PGAIN,
		REG_IGAIN,
		REG_DGAIN,
		REG_OUT_SCALE
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_INC,
		S_ACC,
		S_LOAD1,
		S_MAC1,
		S_MAC2,
		S_DRIVE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [GAIN_W-1:0] gain_a;
		logic [GAIN_W-1:0] gain_b;
		logic [GAIN_W-1:0] gain_c;
	} mac_req_t;

endpackage

/* src/mspid_if.sv */
// Item channels of the motor speed PID controller: speed samples in,
// drive results out. Depends on mspid_pkg.
interface mspid_speed_if;
	import mspid_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [SPEED_BITS-1:0] measured_speed;

	modport source (output valid, output measured_speed, input ready);
	modport sink (input valid, input measured_speed, output ready);
endinterface

interface mspid_drive_if;
	import mspid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [DRIVE_W-1:0]      drive_value;
	logic signed [ERR_W-1:0] speed_error;
	logic [SP_W-1:0]         setpoint_now;
	logic                    reversed;

	modport source (output valid, output drive_value, output speed_error,
		output setpoint_now, output reversed, input ready);
	modport sink (input valid, input drive_value, input speed_error,
		input setpoint_now, input reversed, output ready);
endinterface

/* src/mspid_mac.sv */
// Bit-serial multiply-accumulate unit: sums three signed operands, each
// times an unsigned gain, one gain bit per cycle. Depends on mspid_pkg.
`include "motor_speed_pid_controller_defines.svh"

module mspid_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mspid_pkg::mac_req_t                 req,
	input  logic signed [mspid_pkg::ACC_W-1:0]  op_a,
	input  logic signed [mspid_pkg::ACC_W-1:0]  op_b,
	input  logic signed [mspid_pkg::ACC_W-1:0]  op_c,
	output logic                                busy,
	output logic signed [mspid_pkg::ACC_W-1:0]  acc
);
	import mspid_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

	logic                    busy_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] op_a_q, op_b_q, op_c_q;
	logic [GAIN_W-1:0]       gain_a_q, gain_b_q, gain_c_q;
	logic signed [ACC_W-1:0] sum_d;

	always_comb begin
		sum_d = acc_q;
		if (gain_a_q[0]) begin
			sum_d = sum_d + op_a_q;
		end
		if (gain_b_q[0]) begin
			sum_d = sum_d + op_b_q;
		end
		if (gain_c_q[0]) begin
			sum_d = sum_d + op_c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			op_a_q   <= op_a;
			op_b_q   <= op_b;
			op_c_q   <= op_c;
			gain_a_q <= req.gain_a;
			gain_b_q <= req.gain_b;
			gain_c_q <= req.gain_c;
		end else if (busy_q) begin
			acc_q    <= sum_d;
			op_a_q   <= op_a_q <<< 1;
			op_b_q   <= op_b_q <<< 1;
			op_c_q   <= op_c_q <<< 1;
			gain_a_q <= gain_a_q >> 1;
			gain_b_q <= gain_b_q >> 1;
			gain_c_q <= gain_c_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

	`MSPID_ASSERT_NEXT(a_start_busy, req.start, busy_q, "mac not busy after start")
	`MSPID_ASSERT_NEXT(a_last_step, busy_q && !req.start && cnt_q == CNT_LAST, !busy_q,
		"mac runs past the last gain bit")
	`MSPID_ASSERT_NEXT(a_acc_hold, !busy_q && !req.start, $stable(acc_q),
		"mac result moved while idle")

endmodule

/* src/motor_speed_pid_controller.sv */
// Top level of the motor speed PID controller: configuration registers,
// setpoint square wave, error and integral path, sequencer and result register.
// Depends on mspid_pkg, mspid_if and mspid_mac.

// One speed sample per item gives one drive result. Registers sit on the APB
// port at byte address 4*i in the order nominal_drive, target_level, half_period,
// sample_time, proportional_gain, integral_gain, derivative_gain, output_scale;
// write them only while no item is in flight. After acceptance an item passes
// through the error, integral step and saturation states, then two passes of
// the bit-serial multiply-accumulate unit, each a start step and then one gain
// bit per cycle over the 16-bit gains (PID sum first, output scaling second),
// a state that sees the second pass end, the load of the result and a return
// to idle, where the next item is taken; no new sample is accepted before that
// return.
// The result register lets the next sample in while a result waits; the load
// cycle stretches while an earlier result has not been taken.
`include "motor_speed_pid_controller_defines.svh"

module motor_speed_pid_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mspid_pkg::PADDR_W-1:0]       paddr,
	input  logic [mspid_pkg::DATA_W-1:0]        pwdata,
	output logic [mspid_pkg::DATA_W-1:0]        prdata,
	output logic                                pready,
	mspid_speed_if.sink                         speed_ch,
	mspid_drive_if.source                       drive_ch
);
	import mspid_pkg::*;

	localparam logic signed [SAT_W-1:0] IMAX_S =
		{{(SAT_W - INTEGRAL_BITS + 1){1'b0}}, {(INTEGRAL_BITS - 1){1'b1}}};
	localparam logic signed [SAT_W-1:0] IMIN_S =
		{{(SAT_W - INTEGRAL_BITS + 1){1'b1}}, {(INTEGRAL_BITS - 1){1'b0}}};
	localparam int HI_W = ACC_W + 1 - OUT_FRAC;

	logic [DRIVE_W-1:0]  nominal_drive_q;
	logic [SP_W-1:0]     target_level_q;
	logic [PERIOD_W-1:0] half_period_q;
	logic [STIME_W-1:0]  sample_time_q;
	logic [GAIN_W-1:0]   pgain_q, igain_q, dgain_q, out_scale_q;

	state_t state_q, state_d;

	logic [PERIOD_W-1:0]             period_count_q;
	logic                            phase_q;
	logic signed [INTEGRAL_BITS-1:0] integ_q;
	logic signed [ERR_W-1:0]         prev_err_q;
	logic [DRIVE_W-1:0]              last_drive_q;

	logic [SPEED_BITS-1:0]   speed_q;
	logic [SP_W-1:0]         setpoint_q;
	logic                    rev_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [INC_W-1:0] inc_q;

	logic                    out_valid_q;
	logic [DRIVE_W-1:0]      out_drive_q;
	logic signed [ERR_W-1:0] out_err_q;
	logic [SP_W-1:0]         out_sp_q;
	logic                    out_rev_q;

	logic                    in_ready;
	logic                    in_accept;
	logic                    out_load;
	logic                    cfg_write;

	logic [PERIOD_W:0]       count_d;
	logic                    phase_d;
	logic [PERIOD_W-1:0]     period_d;

	logic [RAW_W-1:0]         sp_ext, spd_ext;
	logic signed [RAW_W-1:0]  raw_s;
	logic signed [ERR_W-1:0]  err_d;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [SAT_W-1:0]  integ_sum;
	logic signed [INTEGRAL_BITS-1:0] integ_d;
	logic signed [ITG_OP_W-1:0] itg_op;

	logic signed [TOT_W-1:0]  tot_c, tadj;
	logic signed [PID_W-1:0]  pid;
	logic signed [ACC_W:0]    val;
	logic signed [HI_W-1:0]   val_hi;
	logic [DRIVE_W-1:0]       drive_d;

	mac_req_t                 mac_req;
	logic signed [ACC_W-1:0]  mac_op_a, mac_op_b, mac_op_c;
	logic                     mac_busy;
	logic signed [ACC_W-1:0]  mac_acc;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_drive_q <= NOMINAL_DRIVE_RST;
			target_level_q  <= TARGET_LEVEL_RST;
			half_period_q   <= HALF_PERIOD_RST;
			sample_time_q   <= SAMPLE_TIME_RST;
			pgain_q         <= PGAIN_RST;
			igain_q         <= IGAIN_RST;
			dgain_q         <= DGAIN_RST;
			out_scale_q     <= OUT_SCALE_RST;
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[PADDR_W-1:2]))
				REG_NOMINAL_DRIVE: nominal_drive_q <= pwdata[DRIVE_W-1:0];
				REG_TARGET_LEVEL:  target_level_q  <= pwdata[SP_W-1:0];
				REG_HALF_PERIOD:   half_period_q   <= pwdata[PERIOD_W-1:0];
				REG_SAMPLE_TIME:   sample_time_q   <= pwdata[STIME_W-1:0];
				REG_PGAIN:         pgain_q         <= pwdata[GAIN_W-1:0];
				REG_IGAIN:         igain_q         <= pwdata[GAIN_W-1:0];
				REG_DGAIN:         dgain_q         <= pwdata[GAIN_W-1:0];
				REG_OUT_SCALE:     out_scale_q     <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[PADDR_W-1:2]))
			REG_NOMINAL_DRIVE: prdata = DATA_W'(nominal_drive_q);
			REG_TARGET_LEVEL:  prdata = DATA_W'(target_level_q);
			REG_HALF_PERIOD:   prdata = DATA_W'(half_period_q);
			REG_SAMPLE_TIME:   prdata = DATA_W'(sample_time_q);
			REG_PGAIN:         prdata = DATA_W'(pgain_q);
			REG_IGAIN:         prdata = DATA_W'(igain_q);
			REG_DGAIN:         prdata = DATA_W'(dgain_q);
			REG_OUT_SCALE:     prdata = DATA_W'(out_scale_q);
			default:           prdata = '0;
		endcase
	end

	// setpoint square wave
	always_comb begin
		count_d  = {1'b0, period_count_q} + 1'b1;
		phase_d  = phase_q;
		period_d = count_d[PERIOD_W-1:0];
		if (count_d >= {1'b0, half_period_q}) begin
			phase_d  = !phase_q;
			period_d = '0;
		end
	end

	// error, derivative difference, integral step
	always_comb begin
		sp_ext  = RAW_W'(setpoint_q);
		spd_ext = RAW_W'(speed_q);
		raw_s   = rev_q ? (sp_ext + spd_ext) : (sp_ext - spd_ext);
		if (raw_s > RAW_W'(ERR_MAX)) begin
			err_d = ERR_W'(ERR_MAX);
		end else if (raw_s < RAW_W'(ERR_MIN)) begin
			err_d = ERR_W'(ERR_MIN);
		end else begin
			err_d = ERR_W'(raw_s);
		end
		diff_d = DIFF_W'(err_d) - DIFF_W'(prev_err_q);
	end

	always_comb begin
		integ_sum = SAT_W'(integ_q) + SAT_W'(inc_q);
		if (integ_sum > IMAX_S) begin
			integ_d = INTEGRAL_BITS'(IMAX_S);
		end else if (integ_sum < IMIN_S) begin
			integ_d = INTEGRAL_BITS'(IMIN_S);
		end else begin
			integ_d = INTEGRAL_BITS'(integ_sum);
		end
	end

	always_comb begin
		if (ITG_CMP_W'(integ_q) > ITG_CMP_W'(ITG_LIM)) begin
			itg_op = ITG_OP_W'(ITG_LIM);
		end else if (ITG_CMP_W'(integ_q) < ITG_CMP_W'(-ITG_LIM)) begin
			itg_op = ITG_OP_W'(-ITG_LIM);
		end else begin
			itg_op = ITG_OP_W'(integ_q);
		end
	end

	// PID sum: saturate, then truncate toward zero
	always_comb begin
		if (mac_acc > ACC_W'(SUM_LIM)) begin
			tot_c = TOT_W'(SUM_LIM);
		end else if (mac_acc < ACC_W'(-SUM_LIM)) begin
			tot_c = TOT_W'(-SUM_LIM);
		end else begin
			tot_c = TOT_W'(mac_acc);
		end
		tadj = tot_c[TOT_W-1] ? (tot_c + TOT_W'(TRUNC_BIAS)) : tot_c;
		pid  = PID_W'(tadj >>> GAIN_FRAC);
	end

	// drive value: base plus scaled correction, floored and saturated
	always_comb begin
		val    = (ACC_W + 1)'($signed({1'b0, nominal_drive_q, {OUT_FRAC{1'b0}}}))
			+ (ACC_W + 1)'(mac_acc);
		val_hi = HI_W'(val >>> OUT_FRAC);
		if (val_hi < 0) begin
			drive_d = '0;
		end else if (val_hi > HI_W'(DRIVE_MAX)) begin
			drive_d = DRIVE_W'(DRIVE_MAX);
		end else begin
			drive_d = DRIVE_W'(val_hi);
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (speed_ch.valid) begin
					state_d = S_ERR;
				end
			end
			S_ERR:   state_d = S_INC;
			S_INC:   state_d = S_ACC;
			S_ACC:   state_d = S_LOAD1;
			S_LOAD1: state_d = S_MAC1;
			S_MAC1: begin
				if (!mac_busy) begin
					state_d = S_MAC2;
				end
			end
			S_MAC2: begin
				if (!mac_busy) begin
					state_d = S_DRIVE;
				end
			end
			S_DRIVE: begin
				if (!out_valid_q || drive_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready       = 1'b0;
		out_load       = 1'b0;
		mac_req.start  = 1'b0;
		mac_req.gain_a = out_scale_q;
		mac_req.gain_b = '0;
		mac_req.gain_c = '0;
		mac_op_a       = ACC_W'(pid);
		mac_op_b       = '0;
		mac_op_c       = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_LOAD1: begin
				mac_req.start  = 1'b1;
				mac_req.gain_a = pgain_q;
				mac_req.gain_b = dgain_q;
				mac_req.gain_c = igain_q;
				mac_op_a       = ACC_W'(err_q);
				mac_op_b       = ACC_W'(diff_q);
				mac_op_c       = ACC_W'(itg_op);
			end
			S_MAC1:  mac_req.start = !mac_busy;
			S_DRIVE: out_load = !out_valid_q || drive_ch.ready;
			default: ;
		endcase
	end

	assign speed_ch.ready = in_ready;
	assign in_accept      = speed_ch.valid && in_ready;

	mspid_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.op_a   (mac_op_a),
		.op_b   (mac_op_b),
		.op_c   (mac_op_c),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			period_count_q <= '0;
			phase_q        <= 1'b0;
			integ_q        <= '0;
			prev_err_q     <= '0;
			last_drive_q   <= NOMINAL_DRIVE_RST;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				period_count_q <= period_d;
				phase_q        <= phase_d;
			end
			if (state_q == S_ERR) begin
				prev_err_q <= err_d;
			end
			if (state_q == S_ACC) begin
				integ_q <= integ_d;
			end
			if (out_load) begin
				last_drive_q <= drive_d;
				out_valid_q  <= 1'b1;
			end else if (drive_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			speed_q    <= speed_ch.measured_speed;
			setpoint_q <= phase_d ? '0 : target_level_q;
			rev_q      <= last_drive_q < nominal_drive_q;
		end
		if (state_q == S_ERR) begin
			err_q  <= err_d;
			diff_q <= diff_d;
		end
		if (state_q == S_INC) begin
			inc_q <= INC_W'(err_q) * INC_W'($signed({1'b0, sample_time_q}));
		end
		if (out_load) begin
			out_drive_q <= drive_d;
			out_err_q   <= err_q;
			out_sp_q    <= setpoint_q;
			out_rev_q   <= rev_q;
		end
	end

	assign drive_ch.valid        = out_valid_q;
	assign drive_ch.drive_value  = out_drive_q;
	assign drive_ch.speed_error  = out_err_q;
	assign drive_ch.setpoint_now = out_sp_q;
	assign drive_ch.reversed     = out_rev_q;

	`MSPID_ASSERT_NEXT(a_accept_err, in_accept, state_q == S_ERR,
		"accepted item did not start the error step")
	`MSPID_ASSERT_NOW(a_mac_in_pass, mac_busy, state_q == S_MAC1 || state_q == S_MAC2,
		"multiply unit busy outside a multiply pass")
	`MSPID_ASSERT_NEXT(a_last_drive, out_load, last_drive_q == drive_ch.drive_value,
		"stored drive differs from the delivered item")

endmodule
